// File: src/lru_weight_slot_cache_core_macros.svh
// ----------------------------------------------------------------------------
// lru weight slot cache assertion macros
// shared assertion forms for the slot cache rtl
// ----------------------------------------------------------------------------
`ifndef LRU_WEIGHT_SLOT_CACHE_CORE_MACROS_SVH
`define LRU_WEIGHT_SLOT_CACHE_CORE_MACROS_SVH

// checked only outside reset
`define LWSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define LWSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: src/lwsc_pkg.sv
// ----------------------------------------------------------------------------
// lwsc_pkg
// types and constants shared by the lru weight slot cache
// ----------------------------------------------------------------------------
package lwsc_pkg;

  // slot storage size
  localparam int unsigned MAX_SLOTS = 128;
  localparam int unsigned SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_SLOTS + 1);

  // field widths
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned ID_W      = 64;
  localparam int unsigned SIZE_W    = 18;
  localparam int unsigned STAMP_W   = 64;
  localparam int unsigned IDX_OUT_W = 7;

  // reset value of the active slot count
  localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(64);

  typedef logic [SLOT_W-1:0]  slot_idx_t;
  typedef logic [STAMP_W-1:0] stamp_t;

  // request transaction
  typedef struct packed {
    logic [ID_W-1:0]   gate_weight_id;
    logic [ID_W-1:0]   up_weight_id;
    logic [ID_W-1:0]   down_weight_id;
    logic [ID_W-1:0]   up_scale_id;
    logic [ID_W-1:0]   gate_scale_id;
    logic [ID_W-1:0]   down_scale_id;
    logic [SIZE_W-1:0] in_channels;
    logic [SIZE_W-1:0] hidden_size;
    logic              fill_ok;
  } req_t;

  // response transaction
  typedef struct packed {
    logic                 hit;
    logic [IDX_OUT_W-1:0] slot_index;
    logic                 fill_failed;
  } rsp_t;

  // stored key of one slot
  typedef struct packed {
    logic [ID_W-1:0]   gate_key;
    logic [ID_W-1:0]   up_key;
    logic [ID_W-1:0]   down_key;
    logic [ID_W-1:0]   up_scale_key;
    logic [ID_W-1:0]   gate_scale_key;
    logic [ID_W-1:0]   down_scale_key;
    logic [SIZE_W-1:0] in_channels;
    logic [SIZE_W-1:0] hidden;
  } key_t;

  // write command into the slot store
  typedef struct packed {
    logic      key_we;
    logic      stamp_we;
    slot_idx_t addr;
    key_t      key;
    stamp_t    stamp;
  } mem_wr_t;

  // key part of a request
  function automatic key_t req_key(req_t r);
    key_t k;
    k.gate_key       = r.gate_weight_id;
    k.up_key         = r.up_weight_id;
    k.down_key       = r.down_weight_id;
    k.up_scale_key   = r.up_scale_id;
    k.gate_scale_key = r.gate_scale_id;
    k.down_scale_key = r.down_scale_id;
    k.in_channels    = r.in_channels;
    k.hidden         = r.hidden_size;
    return k;
  endfunction

endpackage

// File: src/lru_weight_slot_cache_core.sv
// ----------------------------------------------------------------------------
// lru_weight_slot_cache_core
// fully associative slot cache with timestamp lru replacement
// ----------------------------------------------------------------------------
// usage
// - request channel: in_valid_i / in_stall_o / in_data_i. a transaction is
//   taken when valid is high and stall is low; the block stalls while it
//   works on one request.
// - response channel: out_valid_o / out_stall_i / out_data_o, one response
//   per request, held in an output register until taken.
// - config: cfg_we_i writes cfg_wdata_i into the active slot count; write
//   only while idle. 0 acts as 1, values above 128 act as 128.
// - each request scans the n active slots through the single read port of
//   the slot store, one slot per cycle, comparing the key and the stamp in
//   one compare unit. the response is loaded in the update step once the
//   last slot is compared, and the next request can be taken in the cycle
//   after that.
// - reset empties every slot, sets the use clock to 1 and the count to 64.
// - a stalled response does not block the next request; only the final
//   update step waits until the output register is free.
// ----------------------------------------------------------------------------
`include "lru_weight_slot_cache_core_macros.svh"

module lru_weight_slot_cache_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lwsc_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lwsc_pkg::req_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lwsc_pkg::rsp_t              out_data_o
);
  import lwsc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  state_e                 state_q, state_d;
  logic [CFG_W-1:0]       cfg_slots_q, cfg_slots_d;
  logic [MAX_SLOTS-1:0]   valid_q, valid_d;
  stamp_t                 use_clock_q, use_clock_d;
  slot_idx_t              scan_idx_q, scan_idx_d;
  logic                   issue_q, issue_d;
  slot_idx_t              cmp_idx_q, cmp_idx_d;
  logic                   cmp_vld_q, cmp_vld_d;
  logic                   hit_found_q, hit_found_d;
  logic                   inv_found_q, inv_found_d;
  logic                   out_vld_q, out_vld_d;
  rsp_t                   out_q, out_d;

  req_t                   req_q, req_d;
  slot_idx_t              hit_idx_q, hit_idx_d;
  slot_idx_t              inv_idx_q, inv_idx_d;
  slot_idx_t              min_idx_q, min_idx_d;
  stamp_t                 min_stamp_q, min_stamp_d;

  logic [CMP_W-1:0]       cfg_ext;
  logic [CMP_W-1:0]       act_cnt;
  logic [CNT_W-1:0]       last_idx;
  logic                   rd_en;
  mem_wr_t                wr;
  key_t                   rd_key;
  stamp_t                 rd_stamp;
  logic                   cmp_valid_bit;
  logic                   cmp_match;
  logic                   out_free;
  slot_idx_t              victim;
  stamp_t                 new_stamp;

  // slot store
  lwsc_slot_store u_store (
    .clk_i      (clk_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (scan_idx_q),
    .wr_i       (wr),
    .rd_key_o   (rd_key),
    .rd_stamp_o (rd_stamp)
  );

  // active slot count, clamped to 1..MAX_SLOTS
  always_comb begin
    cfg_ext = CMP_W'(cfg_slots_q);
    priority if (cfg_ext == '0) begin
      act_cnt = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_SLOTS)) begin
      act_cnt = CMP_W'(MAX_SLOTS);
    end else begin
      act_cnt = cfg_ext;
    end
    last_idx = CNT_W'(act_cnt - CMP_W'(1));
  end

  // compare unit: key equality and stamp order for the slot just read
  assign cmp_valid_bit = valid_q[cmp_idx_q];
  assign cmp_match     = cmp_valid_bit && (rd_key == req_key(req_q));

  assign out_free  = !out_vld_q || !out_stall_i;
  assign victim    = inv_found_q ? inv_idx_q : min_idx_q;
  assign new_stamp = use_clock_q + STAMP_W'(1);

  // sequencer
  always_comb begin
    state_d     = state_q;
    cfg_slots_d = cfg_slots_q;
    valid_d     = valid_q;
    use_clock_d = use_clock_q;
    scan_idx_d  = scan_idx_q;
    issue_d     = issue_q;
    hit_found_d = hit_found_q;
    inv_found_d = inv_found_q;
    req_d       = req_q;
    hit_idx_d   = hit_idx_q;
    inv_idx_d   = inv_idx_q;
    min_idx_d   = min_idx_q;
    min_stamp_d = min_stamp_q;
    out_vld_d   = out_vld_q && out_stall_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    wr          = '0;
    cmp_vld_d   = (state_q == ST_SCAN) && issue_q;
    cmp_idx_d   = scan_idx_q;

    if (cfg_we_i) begin
      cfg_slots_d = cfg_wdata_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d       = in_data_i;
          scan_idx_d  = '0;
          issue_d     = 1'b1;
          hit_found_d = 1'b0;
          inv_found_d = 1'b0;
          state_d     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue reads in slot order
        if (issue_q) begin
          rd_en = 1'b1;
          if (CNT_W'(scan_idx_q) == last_idx) begin
            issue_d = 1'b0;
          end else begin
            scan_idx_d = scan_idx_q + SLOT_W'(1);
          end
        end
        // track first hit, first empty slot and oldest stamp
        if (cmp_vld_q) begin
          if (cmp_match && !hit_found_q) begin
            hit_found_d = 1'b1;
            hit_idx_d   = cmp_idx_q;
          end
          if (!cmp_valid_bit && !inv_found_q) begin
            inv_found_d = 1'b1;
            inv_idx_d   = cmp_idx_q;
          end
          if ((cmp_idx_q == '0) || (rd_stamp < min_stamp_q)) begin
            min_stamp_d = rd_stamp;
            min_idx_d   = cmp_idx_q;
          end
          if (CNT_W'(cmp_idx_q) == last_idx) begin
            state_d = ST_UPDATE;
          end
        end
      end

      ST_UPDATE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
          if (hit_found_q) begin
            wr.stamp_we       = 1'b1;
            wr.addr           = hit_idx_q;
            wr.stamp          = new_stamp;
            use_clock_d       = new_stamp;
            out_d.hit         = 1'b1;
            out_d.slot_index  = IDX_OUT_W'(hit_idx_q);
            out_d.fill_failed = 1'b0;
          end else begin
            valid_d[victim]   = req_q.fill_ok;
            if (req_q.fill_ok) begin
              wr.key_we   = 1'b1;
              wr.stamp_we = 1'b1;
              wr.addr     = victim;
              wr.key      = req_key(req_q);
              wr.stamp    = new_stamp;
              use_clock_d = new_stamp;
            end
            out_d.hit         = 1'b0;
            out_d.slot_index  = IDX_OUT_W'(victim);
            out_d.fill_failed = !req_q.fill_ok;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_slots_q <= SLOTS_RESET;
      valid_q     <= '0;
      use_clock_q <= STAMP_W'(1);
      scan_idx_q  <= '0;
      issue_q     <= 1'b0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      hit_found_q <= 1'b0;
      inv_found_q <= 1'b0;
      out_vld_q   <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cfg_slots_q <= cfg_slots_d;
      valid_q     <= valid_d;
      use_clock_q <= use_clock_d;
      scan_idx_q  <= scan_idx_d;
      issue_q     <= issue_d;
      cmp_idx_q   <= cmp_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      hit_found_q <= hit_found_d;
      inv_found_q <= inv_found_d;
      out_vld_q   <= out_vld_d;
      out_q       <= out_d;
    end
  end

  // request and scan results
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    hit_idx_q   <= hit_idx_d;
    inv_idx_q   <= inv_idx_d;
    min_idx_q   <= min_idx_d;
    min_stamp_q <= min_stamp_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // assertions
  `LWSC_ASSERT(a_rsp_from_update, $rose(out_valid_o) |-> $past(state_q == ST_UPDATE), "response loaded outside update step")
  `LWSC_ASSERT(a_hit_no_fail, out_valid_o |-> !(out_data_o.hit && out_data_o.fill_failed), "hit reported with failed fill")
  `LWSC_ASSERT(a_clock_step, (use_clock_q != $past(use_clock_q)) |-> ($past(state_q == ST_UPDATE) && (use_clock_q == $past(use_clock_q) + STAMP_W'(1))), "use clock moved outside update or by more than one")
  `LWSC_ASSERT(a_cmp_in_range, cmp_vld_q |-> (CMP_W'(cmp_idx_q) < act_cnt), "compare beyond active slot count")

endmodule

// File: src/lwsc_slot_store.sv
// ----------------------------------------------------------------------------
// lwsc_slot_store
// key and stamp memories, one write port and one registered read port
// ----------------------------------------------------------------------------
module lwsc_slot_store (
  input  logic               clk_i,
  input  logic               rd_en_i,
  input  lwsc_pkg::slot_idx_t rd_addr_i,
  input  lwsc_pkg::mem_wr_t  wr_i,
  output lwsc_pkg::key_t     rd_key_o,
  output lwsc_pkg::stamp_t   rd_stamp_o
);
  import lwsc_pkg::*;

  key_t   key_mem_q   [MAX_SLOTS];
  stamp_t stamp_mem_q [MAX_SLOTS];
  key_t   rd_key_q;
  stamp_t rd_stamp_q;

  // key memory
  always_ff @(posedge clk_i) begin
    if (wr_i.key_we) begin
      key_mem_q[wr_i.addr] <= wr_i.key;
    end
    if (rd_en_i) begin
      rd_key_q <= key_mem_q[rd_addr_i];
    end
  end

  // stamp memory
  always_ff @(posedge clk_i) begin
    if (wr_i.stamp_we) begin
      stamp_mem_q[wr_i.addr] <= wr_i.stamp;
    end
    if (rd_en_i) begin
      rd_stamp_q <= stamp_mem_q[rd_addr_i];
    end
  end

  assign rd_key_o   = rd_key_q;
  assign rd_stamp_o = rd_stamp_q;

endmodule
